[design/sis_pkg.sv]
`default_nettype none

package sis_pkg;

	// Universe of the set. It is matched to the width of the value field.
	localparam int UNIVERSE = 1024;

	localparam int MODE_W  = 3;
	localparam int VALUE_W = 10;
	localparam int IDX_W   = $clog2(UNIVERSE);
	localparam int CNT_W   = IDX_W + 1;

	localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

	typedef struct packed {
		logic sweep;   // write zero into the sparse entry at the sweep pointer
		logic issue;   // transaction accepted: latch it, read sparse and last member
		logic look;    // read the dense slot named by the sparse entry
		logic commit;  // apply the writes and load the result register
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
	} status_t;

	typedef struct packed {
		logic               ok;
		logic               is_member;
		logic [VALUE_W-1:0] popped_value;
		logic [CNT_W-1:0]   population;
		logic               is_empty;
	} rsp_t;

endpackage

`default_nettype wire

[design/sis_req_if.sv]
`default_nettype none

interface sis_req_if import sis_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

[design/sis_rsp_if.sv]
`default_nettype none

interface sis_rsp_if import sis_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic               is_member;
	logic [VALUE_W-1:0] popped_value;
	logic [CNT_W-1:0]   population;
	logic               is_empty;

	modport source (output valid, output ok, output is_member, output popped_value,
		output population, output is_empty, input ready);
	modport sink (input valid, input ok, input is_member, input popped_value,
		input population, input is_empty, output ready);
endinterface

`default_nettype wire

[design/sparse_integer_set_core.sv]
`default_nettype none

// Channel  Dir  Payload                                              Transfer
// req      in   mode[2:0], value[9:0]                                valid & ready
// rsp      out  ok, is_member, popped_value[9:0], population[10:0],  valid & ready
//               is_empty
//
// Each request passes through accept, then two dependent registered reads
// (sparse position, then the dense slot it names) before the writes and result.
// After reset the sparse memory is swept to zero, one entry per cycle, over all 1024
// entries; req.ready stays low during the sweep.
// The result sits in an output register; the next transaction is accepted while
// it waits, and that transaction holds in its final step until the register frees.

module sparse_integer_set_core import sis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sis_req_if.sink   req,
	sis_rsp_if.source rsp
);

	cmd_t    cmd;
	status_t status;
	rsp_t    rsp_data;

	// Control: sequence sweep, lookups and commit; own the handshakes.
	sis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath: both memories, the member count and the result register.
	sis_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_mode  (req.mode),
		.in_value (req.value),
		.status   (status),
		.rsp_data (rsp_data)
	);

	// Drive the result payload straight from the output register.
	assign rsp.ok           = rsp_data.ok;
	assign rsp.is_member    = rsp_data.is_member;
	assign rsp.popped_value = rsp_data.popped_value;
	assign rsp.population   = rsp_data.population;
	assign rsp.is_empty     = rsp_data.is_empty;

endmodule

`default_nettype wire

[design/sis_datapath.sv]
`default_nettype none

module sis_datapath import sis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [MODE_W-1:0]  in_mode,
	input  logic [VALUE_W-1:0] in_value,
	output status_t            status,
	output rsp_t               rsp_data
);

	logic [IDX_W-1:0]   sparse_mem [UNIVERSE];
	logic [VALUE_W-1:0] dense_mem  [UNIVERSE];

	logic [IDX_W-1:0]   sweep_addr_q;
	logic [CNT_W-1:0]   count_q;
	logic [MODE_W-1:0]  mode_q;
	logic [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0]   sparse_rd_q;
	logic [VALUE_W-1:0] dense_rd_q;
	logic [VALUE_W-1:0] last_q;
	rsp_t               rsp_q;

	logic [CNT_W-1:0]   cnt_m1;
	logic               in_range;
	logic               present;
	logic               full;
	logic               empty;
	rsp_t               rsp_n;
	logic [CNT_W-1:0]   count_n;
	logic               sp_we;
	logic [IDX_W-1:0]   sp_waddr;
	logic [IDX_W-1:0]   sp_wdata;
	logic               dn_we;
	logic [IDX_W-1:0]   dn_waddr;
	logic [VALUE_W-1:0] dn_wdata;

	assign cnt_m1            = count_q - 1'b1;
	assign status.sweep_last = (sweep_addr_q == IDX_W'(UNIVERSE - 1));
	assign rsp_data          = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			count_q      <= '0;
		end else begin
			if (cmd.sweep) sweep_addr_q <= sweep_addr_q + 1'b1;
			if (cmd.commit) count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			mode_q  <= in_mode;
			value_q <= in_value;
		end
		if (cmd.look) last_q <= dense_rd_q;
		if (cmd.commit) rsp_q <= rsp_n;
	end

	// Sparse position memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			sparse_mem[sweep_addr_q] <= '0;
		end else if (sp_we) begin
			sparse_mem[sp_waddr] <= sp_wdata;
		end
		if (cmd.issue) sparse_rd_q <= sparse_mem[in_value[IDX_W-1:0]];
	end

	// Dense member memory: last member first, then the slot under test.
	always_ff @(posedge clk) begin
		if (dn_we) dense_mem[dn_waddr] <= dn_wdata;
		if (cmd.issue) begin
			dense_rd_q <= dense_mem[cnt_m1[IDX_W-1:0]];
		end else if (cmd.look) begin
			dense_rd_q <= dense_mem[sparse_rd_q];
		end
	end

	assign in_range = (CNT_W'(value_q) < CNT_W'(UNIVERSE));
	assign present  = in_range && ({1'b0, sparse_rd_q} < count_q) && (dense_rd_q == value_q);
	assign full     = (count_q == CNT_W'(UNIVERSE));
	assign empty    = (count_q == '0);

	always_comb begin
		rsp_n    = '0;
		count_n  = count_q;
		sp_we    = 1'b0;
		sp_waddr = value_q[IDX_W-1:0];
		sp_wdata = count_q[IDX_W-1:0];
		dn_we    = 1'b0;
		dn_waddr = count_q[IDX_W-1:0];
		dn_wdata = value_q;
		unique case (mode_q)
			MODE_INSERT: begin
				rsp_n.is_member = present;
				if (in_range && !present && !full) begin
					rsp_n.ok = 1'b1;
					sp_we    = cmd.commit;
					dn_we    = cmd.commit;
					count_n  = count_q + 1'b1;
				end
			end
			MODE_DELETE: begin
				rsp_n.is_member = present;
				if (present) begin
					// Move the last member into the freed slot.
					rsp_n.ok = 1'b1;
					dn_we    = cmd.commit;
					dn_waddr = sparse_rd_q;
					dn_wdata = last_q;
					sp_we    = cmd.commit;
					sp_waddr = last_q[IDX_W-1:0];
					sp_wdata = sparse_rd_q;
					count_n  = cnt_m1;
				end
			end
			MODE_CONTAINS: begin
				rsp_n.is_member = present;
			end
			MODE_POP: begin
				if (!empty) begin
					rsp_n.ok           = 1'b1;
					rsp_n.popped_value = last_q;
					count_n            = cnt_m1;
				end
			end
			MODE_CLEAR: begin
				count_n = '0;
			end
			default: begin
			end
		endcase
		rsp_n.population = count_n;
		rsp_n.is_empty   = (count_n == '0);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(UNIVERSE))
		else $error("member count above universe");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && rsp_n.ok && mode_q == MODE_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the set by one");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && rsp_n.ok && mode_q == MODE_DELETE |=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not shrink the set by one");

endmodule

`default_nettype wire

[design/sis_ctrl.sv]
`default_nettype none

module sis_ctrl import sis_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_LOOK = 2'd2;
	localparam logic [1:0] S_EVAL = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.sweep  = (state_q == S_CLR);
	assign cmd.issue  = in_valid && in_ready;
	assign cmd.look   = (state_q == S_LOOK);
	assign cmd.commit = (state_q == S_EVAL) && (!out_valid_q || out_ready);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:  if (status.sweep_last) state_n = S_IDLE;
			S_IDLE: if (cmd.issue) state_n = S_LOOK;
			S_LOOK: state_n = S_EVAL;
			S_EVAL: if (cmd.commit) state_n = S_IDLE;
			default: state_n = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_commit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE && out_valid_q)
		else $error("commit did not return to idle with a result");

endmodule

`default_nettype wire

[tb/sv/sparse_integer_set_core_tb.sv]
`timescale 1ns / 100ps

module sparse_integer_set_core_tb;
	import sis_pkg::*;

	// Modes five to seven carry no operation; the block must leave the set alone.
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_CLEAR + 3'd1;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

	localparam int RESET_CYCLES     = 6;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES     = 8;
	localparam int REPORT_LIMIT     = 10;
	localparam int WINDOW_SPAN      = 32;

	logic clk;
	logic arst_n;

	sis_req_if req_ch ();
	sis_rsp_if rsp_ch ();

	sparse_integer_set_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the set: dense member list, sparse position table, count.
	logic [VALUE_W-1:0] shadow_dense  [UNIVERSE];
	logic [IDX_W-1:0]   shadow_sparse [UNIVERSE];
	logic [CNT_W-1:0]   shadow_count;

	// Results owed by the block, oldest first.
	rsp_t pending_results [$];
	int   mismatch_count = 0;

	// Idle controls shared between the test tasks and the result-side process.
	bit sender_gaps     = 1'b1;
	bit receiver_stalls = 1'b1;
	bit long_hold_req   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run; the slowest legal run ends far inside this window.
	initial begin
		#1_000_000;
		$display("sparse_integer_set_core: mismatch");
		$finish;
	end

	// Apply one request to the shadow set and return the result it must produce.
	// A value is a member only when its sparse entry points below the count at a
	// dense slot that holds it, so stale sparse entries left by clear or pop
	// never count.
	function automatic rsp_t apply_set_request(input logic [MODE_W-1:0] op,
			input logic [VALUE_W-1:0] v);
		rsp_t               r;
		logic               present;
		logic [IDX_W-1:0]   slot;
		logic [VALUE_W-1:0] last_v;
		r = '0;
		slot = shadow_sparse[v];
		present = ({1'b0, slot} < shadow_count) && (shadow_dense[slot] == v);
		case (op)
			MODE_INSERT: begin
				r.is_member = present;
				// Refuse a duplicate, and refuse any insert once the set is full.
				if (!present && shadow_count < UNIVERSE) begin
					shadow_sparse[v] = shadow_count[IDX_W-1:0];
					shadow_dense[shadow_count[IDX_W-1:0]] = v;
					shadow_count++;
					r.ok = 1'b1;
				end
			end
			MODE_DELETE: begin
				r.is_member = present;
				// Move the last member into the freed slot and shrink by one.
				if (present) begin
					last_v = shadow_dense[IDX_W'(shadow_count - 1'b1)];
					shadow_dense[slot] = last_v;
					shadow_sparse[last_v] = slot;
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			MODE_CONTAINS: begin
				r.is_member = present;
			end
			MODE_POP: begin
				if (shadow_count != '0) begin
					shadow_count--;
					r.popped_value = shadow_dense[shadow_count[IDX_W-1:0]];
					r.ok = 1'b1;
				end
			end
			MODE_CLEAR: begin
				shadow_count = '0;
			end
			default: begin
			end
		endcase
		r.population = shadow_count;
		r.is_empty   = (shadow_count == '0);
		return r;
	endfunction

	// Weighted mode choice: mostly inserts, deletes and lookups, with pops,
	// the odd clear and some unused modes mixed in.
	function automatic logic [MODE_W-1:0] pick_mode();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return MODE_INSERT;
		if (roll < 60)
			return MODE_DELETE;
		if (roll < 83)
			return MODE_CONTAINS;
		if (roll < 93)
			return MODE_POP;
		if (roll < 95)
			return MODE_CLEAR;
		return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
	endfunction

	// Offer one request from a falling edge and hold it until the block takes it.
	// The caller regains control at a falling edge with valid still high unless
	// a gap was inserted, so the next request follows with no idle cycle.
	task automatic send_request(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] v);
		req_ch.valid <= 1'b1;
		req_ch.mode  <= op;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(apply_set_request(op, v));
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// Hand-picked requests: empty-set corner cases, duplicate insert, absent
	// delete, swap-with-last delete, pop order, unused modes, stale sparse
	// entries after clear, and value extremes.
	task automatic test_directed_cases();
		send_request(MODE_CONTAINS, '0);
		send_request(MODE_POP, '1);
		send_request(MODE_DELETE, '0);
		send_request(MODE_INSERT, '0);
		send_request(MODE_INSERT, '0);
		send_request(MODE_INSERT, VALUE_W'(UNIVERSE - 1));
		send_request(MODE_CONTAINS, VALUE_W'(UNIVERSE - 1));
		send_request(MODE_CONTAINS, '0);
		send_request(MODE_INSERT, VALUE_W'(UNIVERSE / 2));
		// Delete from the front: the last member moves into slot zero.
		send_request(MODE_DELETE, '0);
		send_request(MODE_CONTAINS, VALUE_W'(UNIVERSE / 2));
		send_request(MODE_CONTAINS, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_SPARE_FIRST, '1);
		send_request(MODE_SPARE_FIRST + 3'd1, '1);
		send_request(MODE_SPARE_LAST, '1);
		send_request(MODE_CLEAR, '1);
		// Stale sparse entry after clear must not read as a member.
		send_request(MODE_CONTAINS, VALUE_W'(UNIVERSE / 2));
		send_request(MODE_INSERT, VALUE_W'(UNIVERSE / 2));
		// Delete of the only (and so the last) member.
		send_request(MODE_DELETE, VALUE_W'(UNIVERSE / 2));
		send_request(MODE_POP, '0);
		send_request(MODE_INSERT, 10'b0101010101);
		send_request(MODE_INSERT, 10'b1010101010);
		send_request(MODE_DELETE, 10'b1010101010);
		send_request(MODE_POP, '1);
	endtask

	// Insert every value of the universe in shuffled order, then poke at the
	// full set: refused insert, lookups, delete and refill, pops.
	task automatic test_fill_to_capacity();
		int order [UNIVERSE];
		int pick;
		int swap_v;
		for (int i = 0; i < UNIVERSE; i++)
			order[i] = i;
		for (int i = UNIVERSE - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			swap_v = order[i];
			order[i] = order[pick];
			order[pick] = swap_v;
		end
		send_request(MODE_CLEAR, '0);
		for (int i = 0; i < UNIVERSE; i++) begin
			// Switch idling on and off in stretches so some run back to back.
			if (i % 128 == 0) begin
				sender_gaps     = 1'($urandom_range(0, 1));
				receiver_stalls = 1'($urandom_range(0, 1));
			end
			send_request(MODE_INSERT, VALUE_W'(order[i]));
		end
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		send_request(MODE_INSERT, VALUE_W'($urandom_range(0, UNIVERSE - 1)));
		send_request(MODE_CONTAINS, '0);
		send_request(MODE_CONTAINS, '1);
		send_request(MODE_DELETE, VALUE_W'(order[0]));
		send_request(MODE_INSERT, VALUE_W'(order[0]));
		send_request(MODE_INSERT, VALUE_W'(order[UNIVERSE - 1]));
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '1);
	endtask

	// Hold the result side off for a long stretch while requests keep coming,
	// so the output register and the pipeline fill and the block stalls input.
	task automatic test_output_backpressure();
		sender_gaps   = 1'b0;
		long_hold_req = 1'b1;
		repeat (24)
			send_request(pick_mode(), VALUE_W'($urandom_range(0, UNIVERSE - 1)));
		sender_gaps = 1'b1;
	endtask

	// Random traffic. Most values come from a narrow window that moves every
	// fifty requests, so deletes and lookups hit members often.
	task automatic test_random_mix(input int count);
		int                 window_base;
		logic [VALUE_W-1:0] v;
		window_base = 0;
		send_request(MODE_CLEAR, VALUE_W'($urandom_range(0, UNIVERSE - 1)));
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				window_base     = $urandom_range(0, UNIVERSE - WINDOW_SPAN);
				sender_gaps     = ($urandom_range(0, 3) != 0);
				receiver_stalls = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 3) != 0)
				v = VALUE_W'(window_base + $urandom_range(0, WINDOW_SPAN - 1));
			else
				v = VALUE_W'($urandom_range(0, UNIVERSE - 1));
			send_request(pick_mode(), v);
		end
	endtask

	// Last stretch at full rate with no idling, then pop the set down to empty.
	task automatic test_final_drain(input int count);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int i = 0; i < count; i++)
			send_request(pick_mode(), VALUE_W'($urandom_range(0, WINDOW_SPAN - 1)));
		while (shadow_count != '0)
			send_request(MODE_POP, VALUE_W'($urandom_range(0, UNIVERSE - 1)));
		send_request(MODE_POP, '0);
	endtask

	// Result side: drive ready from falling edges. A long hold requested by a
	// test takes priority over the short random stalls.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every result transaction with the oldest pending expectation.
	always @(posedge clk) begin : check_results
		rsp_t seen;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.ok           = rsp_ch.ok;
			seen.is_member    = rsp_ch.is_member;
			seen.popped_value = rsp_ch.popped_value;
			seen.population   = rsp_ch.population;
			seen.is_empty     = rsp_ch.is_empty;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with nothing pending:", $realtime,
						" ok=%0b member=%0b popped=%0d pop=%0d empty=%0b",
						seen.ok, seen.is_member, seen.popped_value,
						seen.population, seen.is_empty);
			end else begin
				want = pending_results.pop_front();
				if (seen.ok !== want.ok || seen.is_member !== want.is_member ||
						seen.popped_value !== want.popped_value ||
						seen.population !== want.population ||
						seen.is_empty !== want.is_empty) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: expected", $realtime,
							" ok=%0b member=%0b popped=%0d pop=%0d empty=%0b,",
							want.ok, want.is_member, want.popped_value,
							want.population, want.is_empty,
							" got ok=%0b member=%0b popped=%0d pop=%0d empty=%0b",
							seen.ok, seen.is_member, seen.popped_value,
							seen.population, seen.is_empty);
				end
			end
		end
	end

	// Main sequence: reset once, run the tests in turn, drain and report.
	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.mode   = MODE_INSERT;
		req_ch.value  = '0;
		shadow_count  = '0;
		for (int i = 0; i < UNIVERSE; i++) begin
			shadow_dense[i]  = '0;
			shadow_sparse[i] = '0;
		end
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		// The block sweeps its sparse table after reset; requests simply wait
		// on ready until that finishes.
		test_directed_cases();
		test_fill_to_capacity();
		test_output_backpressure();
		test_random_mix(420);
		test_final_drain(60);
		// Drop valid on the same falling edge the last transaction returned on.
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sparse_integer_set_core: match");
		else
			$display("sparse_integer_set_core: mismatch");
		$finish;
	end

endmodule
